FILE: design/bppc_pkg.sv
// ----------------------------------------------------------------------------
// bppc_pkg
// Shared types, codes and address helpers for the bitplane plot pixel cache.
// ----------------------------------------------------------------------------
package bppc_pkg;

    typedef enum logic [1:0] {
        K_SET_COLOR = 2'd0,
        K_PLOT      = 2'd1,
        K_READ      = 2'd2,
        K_HOST_WR   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        R_TRANSPARENT = 3'd0,
        R_DITHER      = 3'd1,
        R_HIGH_NIBBLE = 3'd2,
        R_FREEZE_HIGH = 3'd3,
        R_OBJ_LAYOUT  = 3'd4,
        R_DEPTH       = 3'd5,
        R_HEIGHT      = 3'd6,
        R_BASE        = 3'd7
    } t_reg_idx;

    localparam logic [1:0] DEPTH_8BPP = 2'd3;
    localparam logic [1:0] LAYOUT_OBJ = 2'd3;
    localparam logic [23:0] FRAME_ORG = 24'h700000;

    typedef struct packed {
        logic       transparent;
        logic       dither;
        logic       high_nibble;
        logic       freeze_high;
        logic       obj_layout;
        logic [1:0] depth;
        logic [1:0] height;
        logic [7:0] base;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  data;
        logic [16:0] addr;
    } t_cmd;

    function automatic logic [2:0] last_plane(input logic [1:0] depth);
        case (depth)
            2'd0:       last_plane = 3'd1;
            DEPTH_8BPP: last_plane = 3'd7;
            default:    last_plane = 3'd3;
        endcase
    endfunction

    function automatic logic [23:0] tile_row(input logic [7:0] x, input logic [7:0] y,
                                             input t_cfg cfg);
        logic [1:0]  layout;
        logic [11:0] xs;
        logic [11:0] cn;
        logic [23:0] scaled;
        layout = cfg.obj_layout ? LAYOUT_OBJ : cfg.height;
        xs     = {4'd0, x & 8'hf8};
        case (layout)
            2'd0:    cn = (xs << 1) + 12'({y[7:3]});
            2'd1:    cn = (xs << 1) + (xs >> 1) + 12'({y[7:3]});
            2'd2:    cn = (xs << 1) + xs + 12'({y[7:3]});
            default: cn = {2'd0, y[7], x[7], y[6:3], x[6:3]};
        endcase
        case (cfg.depth)
            2'd0:       scaled = 24'(cn) << 4;
            DEPTH_8BPP: scaled = 24'(cn) << 6;
            default:    scaled = 24'(cn) << 5;
        endcase
        tile_row = FRAME_ORG + scaled + {6'd0, cfg.base, 10'd0} + 24'({y[2:0], 1'b0});
    endfunction

endpackage

FILE: design/bppc_if.sv
// ----------------------------------------------------------------------------
// bppc_if
// Request, result and configuration channels of the plot pixel cache.
// ----------------------------------------------------------------------------
interface bppc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  value;
    logic [16:0] ram_address;
    modport source(output valid, kind, pos_x, pos_y, value, ram_address, input ready);
    modport sink(input valid, kind, pos_x, pos_y, value, ram_address, output ready);
endinterface

interface bppc_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [16:0] out_address;
    logic [7:0]  out_data;
    logic        last;
    modport source(output valid, result_kind, out_address, out_data, last, input ready);
    modport sink(input valid, result_kind, out_address, out_data, last, output ready);
endinterface

interface bppc_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: design/bitplane_plot_pixel_cache.sv
// ----------------------------------------------------------------------------
// bitplane_plot_pixel_cache
// Planar-tile plot engine with a two-line pixel cache and internal frame RAM.
// ----------------------------------------------------------------------------
// channel   dir  payload                                    accept
// i_item    in   kind pos_x pos_y value ram_address          valid & ready
// o_result  out  result_kind out_address out_data last       valid & ready
// i_cfg     in   index data                                 valid & ready
//
// Set color and skipped plots retire in the front; others queue.
// A cache-hit plot passes the back's idle and plot states; a line change or
// full line adds a flush start, a write per plane (a read first if partial)
// and continue. Read pixel flushes both lines, then gathers each plane's bit.
// Reset is synchronous; the frame RAM and line pixels are not cleared.
// A stalled result blocks the back; the front keeps taking requests until
// the two-entry queue is full.
// ----------------------------------------------------------------------------
module bitplane_plot_pixel_cache
    import bppc_pkg::*;
#(
    parameter int RAM_ADDR_BITS = 17
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bppc_item_if.sink    i_item,
    bppc_result_if.source o_result,
    bppc_cfg_if.sink     i_cfg
);

    t_cfg r_cfg;
    t_cmd w_req;
    t_cmd w_push_cmd;
    t_cmd w_pop_cmd;
    logic w_push;
    logic w_push_ready;
    logic w_pop_valid;
    logic w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                R_TRANSPARENT: r_cfg.transparent <= i_cfg.data[0];
                R_DITHER:      r_cfg.dither      <= i_cfg.data[0];
                R_HIGH_NIBBLE: r_cfg.high_nibble <= i_cfg.data[0];
                R_FREEZE_HIGH: r_cfg.freeze_high <= i_cfg.data[0];
                R_OBJ_LAYOUT:  r_cfg.obj_layout  <= i_cfg.data[0];
                R_DEPTH:       r_cfg.depth       <= i_cfg.data[1:0];
                R_HEIGHT:      r_cfg.height      <= i_cfg.data[1:0];
                R_BASE:        r_cfg.base        <= i_cfg.data;
                default:       r_cfg             <= r_cfg;
            endcase
        end
    end

    assign w_req = '{kind: t_kind'(i_item.kind), x: i_item.pos_x, y: i_item.pos_y,
                     data: i_item.value, addr: i_item.ram_address};

    bppc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_item.valid),
        .o_ready      (i_item.ready),
        .i_req        (w_req),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_cmd        (w_push_cmd)
    );

    bppc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_cmd        (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_cmd        (w_pop_cmd)
    );

    bppc_back #(
        .RAM_ADDR_BITS (RAM_ADDR_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (w_pop_valid),
        .o_pop         (w_pop),
        .i_cmd         (w_pop_cmd),
        .o_valid       (o_result.valid),
        .i_ready       (o_result.ready),
        .o_result_kind (o_result.result_kind),
        .o_out_address (o_result.out_address),
        .o_out_data    (o_result.out_data),
        .o_last        (o_result.last)
    );

    a_pixel_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.result_kind |-> o_result.last)
        else $error("pixel result without last");

    a_pixel_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.result_kind |-> o_result.out_address == 17'd0)
        else $error("pixel result with address");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid after reset");

endmodule

FILE: design/bppc_front.sv
// ----------------------------------------------------------------------------
// bppc_front
// Accepts requests, keeps the color register, filters plots, queues work.
// ----------------------------------------------------------------------------
module bppc_front
    import bppc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_req,
    output logic        o_push,
    input  logic        i_push_ready,
    output t_cmd        o_cmd
);

    logic [7:0] r_color;
    logic [7:0] w_c;
    logic       w_skip;
    logic       w_take;

    always_comb begin
        w_c = r_color;
        if (i_cfg.dither && i_cfg.depth != DEPTH_8BPP) begin
            if (i_req.x[0] ^ i_req.y[0]) w_c = r_color >> 4;
            w_c = w_c & 8'h0f;
        end
        w_skip = 1'b0;
        if (!i_cfg.transparent) begin
            if (i_cfg.depth == DEPTH_8BPP && !i_cfg.freeze_high) w_skip = (w_c == 8'd0);
            else w_skip = (w_c[3:0] == 4'd0);
        end
    end

    assign o_ready = i_push_ready;
    assign w_take  = i_valid && i_push_ready;
    assign o_push  = w_take && i_req.kind != K_SET_COLOR &&
                     !(i_req.kind == K_PLOT && w_skip);

    always_comb begin
        o_cmd = i_req;
        if (i_req.kind == K_PLOT) o_cmd.data = w_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= 8'd0;
        end else if (w_take && i_req.kind == K_SET_COLOR) begin
            if (i_cfg.high_nibble) r_color <= {r_color[7:4], i_req.data[7:4]};
            else if (i_cfg.freeze_high) r_color <= {r_color[7:4], i_req.data[3:0]};
            else r_color <= i_req.data;
        end
    end

endmodule

FILE: design/bppc_queue.sv
// ----------------------------------------------------------------------------
// bppc_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module bppc_queue
    import bppc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_push_ready,
    input  t_cmd i_cmd,
    output logic o_pop_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_push_ready = r_cnt != 2'd2;
    assign o_pop_valid  = r_cnt != 2'd0;
    assign o_cmd        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: design/bppc_back.sv
// ----------------------------------------------------------------------------
// bppc_back
// Line cache, flush sequencer, frame RAM and result register.
// ----------------------------------------------------------------------------
module bppc_back
    import bppc_pkg::*;
#(
    parameter int RAM_ADDR_BITS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_cmd_valid,
    output logic        o_pop,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [16:0] o_out_address,
    output logic [7:0]  o_out_data,
    output logic        o_last
);

    localparam int AW = RAM_ADDR_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_PLOT, S_FL_START, S_FL_RD, S_FL_WR, S_CONT,
        S_G_RD, S_G_ACC, S_G_OUT, S_HOST
    } t_state;

    typedef enum logic [1:0] {
        C_AGE_MISS, C_AGE_FULL, C_READ0, C_READ_GATHER
    } t_cont;

    t_state      r_state;
    t_cont       r_cont;
    t_cmd        r_cmd;
    logic        r_line;
    logic [2:0]  r_n;
    logic [7:0]  r_gd;
    logic [12:0] r_off [2];
    logic [7:0]  r_pend [2];
    logic [7:0]  r_pix [16];
    logic [7:0]  r_mem [2**AW];
    logic [7:0]  r_rd_data;

    logic [12:0]   w_off;
    logic [2:0]    w_slot;
    logic [7:0]    w_bit;
    logic [7:0]    w_pend0;
    logic [7:0]    w_lpend;
    logic [12:0]   w_loff;
    logic [23:0]   w_fl_base;
    logic [23:0]   w_rd_base;
    logic [AW-1:0] w_base;
    logic [AW-1:0] w_paddr;
    logic [AW-1:0] w_host_addr;
    logic [19:0]   w_wide;
    logic [7:0]    w_planes;
    logic [7:0]    w_fl_data;
    logic          w_free;
    logic          w_emit;
    logic          w_last_n;
    logic          w_rd_en;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;

    assign w_off     = {r_cmd.y, r_cmd.x[7:3]};
    assign w_slot    = r_cmd.x[2:0] ^ 3'd7;
    assign w_bit     = 8'd1 << w_slot;
    assign w_pend0   = r_pend[0] | w_bit;
    assign w_lpend   = r_pend[r_line];
    assign w_loff    = r_off[r_line];
    assign w_fl_base = tile_row({w_loff[4:0], 3'd0}, w_loff[12:5], i_cfg);
    assign w_rd_base = tile_row(r_cmd.x, r_cmd.y, i_cfg);
    assign w_base    = (r_state == S_G_RD) ? w_rd_base[AW-1:0] : w_fl_base[AW-1:0];
    assign w_paddr   = w_base + AW'({r_n[2:1], 4'd0}) + AW'(r_n[0]);
    assign w_host_addr = AW'(r_cmd.addr);
    assign w_free    = !o_valid || i_ready;
    assign w_emit    = w_free &&
                       (r_state == S_FL_WR || r_state == S_G_OUT || r_state == S_HOST);
    assign w_last_n  = r_n == last_plane(i_cfg.depth);

    always_comb begin
        for (int p = 0; p < 8; p++) w_planes[p] = r_pix[{r_line, 3'(p)}][r_n];
        if (w_lpend == 8'hff) w_fl_data = w_planes;
        else w_fl_data = (w_planes & w_lpend) | (r_rd_data & ~w_lpend);
    end

    assign w_rd_en   = r_state == S_FL_RD || r_state == S_G_RD;
    assign w_wr_en   = w_free && (r_state == S_FL_WR || r_state == S_HOST);
    assign w_wr_addr = (r_state == S_HOST) ? w_host_addr : w_paddr;
    assign w_wr_data = (r_state == S_HOST) ? r_cmd.data : w_fl_data;
    assign w_wide    = 20'(w_wr_addr);
    assign o_pop     = r_state == S_IDLE && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_rd_en) r_rd_data <= r_mem[w_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cont  <= C_AGE_MISS;
            r_line  <= 1'b0;
            r_n     <= 3'd0;
            r_off   <= '{default: '0};
            r_pend  <= '{default: '0};
            o_valid <= 1'b0;
        end else begin
            if (w_emit) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.kind)
                            K_PLOT: r_state <= S_PLOT;
                            K_READ: begin
                                r_line  <= 1'b1;
                                r_cont  <= C_READ0;
                                r_state <= S_FL_START;
                            end
                            default: r_state <= S_HOST;
                        endcase
                    end
                end
                S_PLOT: begin
                    if (w_off != r_off[0]) begin
                        r_line  <= 1'b1;
                        r_cont  <= C_AGE_MISS;
                        r_state <= S_FL_START;
                    end else begin
                        r_pix[{1'b0, w_slot}] <= r_cmd.data;
                        r_pend[0] <= w_pend0;
                        if (w_pend0 == 8'hff) begin
                            r_line  <= 1'b1;
                            r_cont  <= C_AGE_FULL;
                            r_state <= S_FL_START;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FL_START: begin
                    r_n <= 3'd0;
                    if (w_lpend == 8'd0) r_state <= S_CONT;
                    else if (w_lpend == 8'hff) r_state <= S_FL_WR;
                    else r_state <= S_FL_RD;
                end
                S_FL_RD: r_state <= S_FL_WR;
                S_FL_WR: begin
                    if (w_free) begin
                        o_result_kind <= 1'b0;
                        o_out_address <= w_wide[16:0];
                        o_out_data    <= w_fl_data;
                        o_last        <= w_last_n &&
                                         (r_cont == C_AGE_MISS || r_cont == C_AGE_FULL);
                        if (w_last_n) begin
                            r_pend[r_line] <= 8'd0;
                            r_state        <= S_CONT;
                        end else begin
                            r_n     <= r_n + 3'd1;
                            r_state <= (w_lpend == 8'hff) ? S_FL_WR : S_FL_RD;
                        end
                    end
                end
                S_CONT: begin
                    case (r_cont)
                        C_AGE_MISS, C_AGE_FULL: begin
                            r_off[1]  <= r_off[0];
                            r_pend[1] <= r_pend[0];
                            for (int p = 0; p < 8; p++) r_pix[8 + p] <= r_pix[p];
                            if (r_cont == C_AGE_MISS) begin
                                r_off[0]  <= w_off;
                                r_pend[0] <= w_bit;
                                r_pix[{1'b0, w_slot}] <= r_cmd.data;
                            end else begin
                                r_pend[0] <= 8'd0;
                            end
                            r_state <= S_IDLE;
                        end
                        C_READ0: begin
                            r_line  <= 1'b0;
                            r_cont  <= C_READ_GATHER;
                            r_state <= S_FL_START;
                        end
                        default: begin
                            r_n     <= 3'd0;
                            r_gd    <= 8'd0;
                            r_state <= S_G_RD;
                        end
                    endcase
                end
                S_G_RD: r_state <= S_G_ACC;
                S_G_ACC: begin
                    r_gd[r_n] <= r_rd_data[r_cmd.x[2:0] ^ 3'd7];
                    if (w_last_n) begin
                        r_state <= S_G_OUT;
                    end else begin
                        r_n     <= r_n + 3'd1;
                        r_state <= S_G_RD;
                    end
                end
                S_G_OUT: begin
                    if (w_free) begin
                        o_result_kind <= 1'b1;
                        o_out_address <= 17'd0;
                        o_out_data    <= r_gd;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_HOST: begin
                    if (w_free) begin
                        o_result_kind <= 1'b0;
                        o_out_address <= w_wide[16:0];
                        o_out_data    <= r_cmd.data;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
